>>> rtl/core/tflr_pkg.sv
// shared constants for the task free and ready list core
// field widths, operation codes and status codes; no dependencies
package tflr_pkg;

   localparam int TASK_SLOTS_DEFAULT = 64;

   localparam int FUNC_W   = 2;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

endpackage

>>> rtl/core/tflr_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module tflr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/task_free_and_ready_lists_core.sv
// Task table with a free list and a ready queue threaded through one link memory.
// A transaction is taken in the idle state, which reads the link of the relevant
// list head from the link ram, and the execute state updates the heads and
// tails, writes at most one link and registers the result. The result shows on the
// rsp_ ports for one cycle under rsp_strobe, in the same cycle in which busy drops,
// and cannot be stalled. The next transaction may be started in that same cycle.
// After reset the block stays busy while it initialises the link memory, one entry
// per cycle. Depends on tflr_pkg and tflr_ram.
module task_free_and_ready_lists_core #(
   parameter int TASK_SLOTS = tflr_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [tflr_pkg::FUNC_W-1:0]   req_func,
   input  logic [tflr_pkg::INDEX_W-1:0]  req_task_index,
   output logic                          rsp_strobe,
   output logic [tflr_pkg::STATUS_W-1:0] rsp_status,
   output logic [tflr_pkg::INDEX_W-1:0]  rsp_given_task,
   output logic [tflr_pkg::INDEX_W-1:0]  rsp_next_task,
   output logic                          rsp_next_valid
);
   import tflr_pkg::*;

   localparam int IDX_W = $clog2(TASK_SLOTS);
   localparam int PTR_W = IDX_W + 1;
   localparam logic [PTR_W-1:0] MARK     = PTR_W'(TASK_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

   localparam logic [1:0] S_INIT = 2'd0;
   localparam logic [1:0] S_IDLE = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [PTR_W-1:0]   free_head_ff, free_head_in, free_tail_ff, free_tail_in;
   logic [PTR_W-1:0]   ready_head_ff, ready_head_in, ready_tail_ff, ready_tail_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [INDEX_W-1:0] idx_ff, idx_in;

   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [INDEX_W-1:0]  rsp_given_ff, rsp_given_in;
   logic [INDEX_W-1:0]  rsp_next_ff, rsp_next_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic             accept;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic [PTR_W-1:0] rd_link;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [PTR_W-1:0] wr_data;

   // working values for the execute cycle
   logic             idx_in_range;
   logic             free_empty, ready_empty;
   logic [PTR_W-1:0] got, nxt, push_val, given;
   logic             push_ready, push_free;
   logic [STATUS_W-1:0] status;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // the pop target is read as the transaction is taken
   assign rd_en   = accept;
   assign rd_addr = (req_func == FUNC_STOP) ? ready_head_ff[IDX_W-1:0]
                                            : free_head_ff[IDX_W-1:0];

   tflr_ram #(
      .WIDTH (PTR_W),
      .DEPTH (TASK_SLOTS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_link)
   );

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      free_head_in  = free_head_ff;
      free_tail_in  = free_tail_ff;
      ready_head_in = ready_head_ff;
      ready_tail_in = ready_tail_ff;
      func_in       = func_ff;
      idx_in        = idx_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_given_in  = rsp_given_ff;
      rsp_next_in   = rsp_next_ff;
      rsp_valid_in  = rsp_valid_ff;
      wr_en         = 1'b0;
      wr_addr       = clr_ff;
      wr_data       = PTR_W'(clr_ff) + PTR_W'(1);

      idx_in_range = (32'(idx_ff) < 32'(TASK_SLOTS));
      free_empty   = (free_head_ff >= MARK);
      ready_empty  = (ready_head_ff >= MARK);
      got          = (func_ff == FUNC_STOP) ? ready_head_ff : free_head_ff;
      nxt          = rd_link;
      push_val     = PTR_W'(idx_ff);
      push_ready   = 1'b0;
      push_free    = 1'b0;
      given        = '0;
      status       = STATUS_OK;

      case (state_ff)
         S_INIT: begin
            wr_en = 1'b1;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               func_in  = req_func;
               idx_in   = req_task_index;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (func_ff)
               FUNC_CREATE: begin
                  if (free_empty) begin
                     status = STATUS_NOFREE;
                  end else begin
                     given = got;
                     if (got == free_tail_ff) begin
                        nxt = MARK;
                     end
                     if (nxt >= MARK) begin
                        free_head_in = MARK;
                        free_tail_in = MARK;
                     end else begin
                        free_head_in = nxt;
                     end
                     push_val   = got;
                     push_ready = 1'b1;
                  end
               end
               FUNC_RUN: begin
                  push_ready = idx_in_range;
               end
               FUNC_STOP: begin
                  if (ready_empty) begin
                     status = STATUS_EMPTY;
                  end else begin
                     given = got;
                     if (got == ready_tail_ff) begin
                        nxt = MARK;
                     end
                     if (nxt >= MARK) begin
                        ready_head_in = MARK;
                        ready_tail_in = MARK;
                     end else begin
                        ready_head_in = nxt;
                     end
                  end
               end
               default: begin
                  push_free = idx_in_range;
               end
            endcase

            // append to a list: either restart it or link from its tail
            if (push_ready) begin
               if (ready_empty || (ready_tail_ff >= MARK)) begin
                  ready_head_in = push_val;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = ready_tail_ff[IDX_W-1:0];
                  wr_data = push_val;
               end
               ready_tail_in = push_val;
            end
            if (push_free) begin
               if (free_empty || (free_tail_ff >= MARK)) begin
                  free_head_in = push_val;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = free_tail_ff[IDX_W-1:0];
                  wr_data = push_val;
               end
               free_tail_in = push_val;
            end

            rsp_strobe_in = 1'b1;
            rsp_status_in = status;
            rsp_given_in  = INDEX_W'(given);
            rsp_valid_in  = (ready_head_in < MARK);
            rsp_next_in   = rsp_valid_in ? INDEX_W'(ready_head_in) : '0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         clr_ff        <= '0;
         free_head_ff  <= '0;
         free_tail_ff  <= PTR_W'(TASK_SLOTS - 1);
         ready_head_ff <= MARK;
         ready_tail_ff <= MARK;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_head_ff  <= free_head_in;
         free_tail_ff  <= free_tail_in;
         ready_head_ff <= ready_head_in;
         ready_tail_ff <= ready_tail_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_given_ff  <= rsp_given_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_valid_ff  <= rsp_valid_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_given_task = rsp_given_ff;
   assign rsp_next_task  = rsp_next_ff;
   assign rsp_next_valid = rsp_valid_ff;

endmodule
